/* hw/rtl/wswm_pkg.sv */
// shared types, constants and codes of the wheel speed window monitor
`default_nettype none

package wswm_pkg;

    // field widths
    localparam int SPEED_W = 16;
    localparam int CNT_W   = 8;
    localparam int LEN_W   = 8;
    localparam int AVG_W   = 24;
    localparam int SUM_W   = 24;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // default number of fraction bits of the average
    localparam int AVG_FRAC_BITS_DEF = 8;

    // configuration reset values
    localparam logic [SPEED_W-1:0] NOISE_LIMIT_RST     = 16'd250;
    localparam logic [SPEED_W-1:0] DROP_THRESHOLD_RST  = 16'd30;
    localparam logic [SPEED_W-1:0] OVERSPEED_LIMIT_RST = 16'd120;
    localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RST   = 8'd10;

    // running minimum starts at the top of the range
    localparam logic [SPEED_W-1:0] MIN_RST = 16'hFFFF;

    // fault codes
    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_DROP      = 2'd1;
    localparam logic [1:0] FAULT_OVERSPEED = 2'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOISE_LIMIT     = 2'd0,
        CFG_DROP_THRESHOLD  = 2'd1,
        CFG_OVERSPEED_LIMIT = 2'd2,
        CFG_WINDOW_LENGTH   = 2'd3
    } t_cfg_idx;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic acc;        // take one sample item
        logic div_start;  // snapshot the window and start the divider
        logic div_step;   // one quotient bit
        logic out_load;   // move the finished report to the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic win_end;    // the next sample closes the window
        logic div_last;   // divider is on its last bit
        logic out_free;   // output register can take a report this cycle
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/wswm_ctrl.sv */
// controller of the wheel speed window monitor: sample intake and divider sequencing
`default_nettype none

module wswm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire wswm_pkg::t_status i_status,
    output wswm_pkg::t_cmd         o_cmd
);

    wswm_pkg::t_state r_state;
    wswm_pkg::t_state n_state;

    // a closing sample waits while the divider still holds the previous window
    assign o_stall = i_status.win_end && (r_state != wswm_pkg::ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wswm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wswm_pkg::ST_IDLE: begin
                if (i_valid && i_status.win_end) begin
                    n_state = wswm_pkg::ST_DIV;
                end
            end
            wswm_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = wswm_pkg::ST_DONE;
                end
            end
            wswm_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = wswm_pkg::ST_IDLE;
                end
            end
            default: n_state = wswm_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.acc       = i_valid && !o_stall;
        o_cmd.div_start = i_valid && !o_stall && i_status.win_end;
        case (r_state)
            wswm_pkg::ST_IDLE: ;
            wswm_pkg::ST_DIV:  o_cmd.div_step = 1'b1;
            wswm_pkg::ST_DONE: o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/wswm_dp.sv */
// datapath of the wheel speed window monitor: config, accumulators, divider, report register
`default_nettype none

module wswm_dp #(
    parameter int AVG_FRAC_BITS = wswm_pkg::AVG_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [wswm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wswm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic [wswm_pkg::SPEED_W-1:0]    i_speed_sample,
    input  wire logic                            i_stall,
    input  wire wswm_pkg::t_cmd                  i_cmd,
    output wswm_pkg::t_status                    o_status,
    output logic                                 o_valid,
    output logic [wswm_pkg::AVG_W-1:0]           o_average_q8,
    output logic [wswm_pkg::SPEED_W-1:0]         o_speed_max,
    output logic [wswm_pkg::SPEED_W-1:0]         o_speed_min,
    output logic [wswm_pkg::CNT_W-1:0]           o_valid_samples,
    output logic [1:0]                           o_fault_code,
    output logic                                 o_all_discarded
);

    localparam int SW  = wswm_pkg::SPEED_W;
    localparam int CW  = wswm_pkg::CNT_W;
    localparam int LW  = wswm_pkg::LEN_W;
    localparam int AW  = wswm_pkg::AVG_W;
    localparam int UW  = wswm_pkg::SUM_W;
    localparam int DW  = UW + AVG_FRAC_BITS;   // dividend and quotient width
    localparam int STW = $clog2(DW);
    localparam logic [DW-1:0] AVG_SAT = DW'({AW{1'b1}});

    // configuration registers
    logic [SW-1:0] r_noise_limit;
    logic [SW-1:0] r_drop_threshold;
    logic [SW-1:0] r_overspeed_limit;
    logic [LW-1:0] r_window_length;

    // window accumulators
    logic [UW-1:0] r_sum;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_max;
    logic [SW-1:0] r_min;
    logic [SW-1:0] r_prev;
    logic [LW-1:0] r_pos;
    logic          r_drop;

    logic [UW-1:0] n_sum;
    logic [CW-1:0] n_cnt;
    logic [SW-1:0] n_max;
    logic [SW-1:0] n_min;
    logic          n_drop;

    // snapshot of a closed window and divider state
    logic [UW-1:0]  r_snap_sum;
    logic [CW-1:0]  r_snap_cnt;
    logic [SW-1:0]  r_snap_max;
    logic [SW-1:0]  r_snap_min;
    logic           r_snap_drop;
    logic [DW-1:0]  r_div_q;
    logic [CW-1:0]  r_div_rem;
    logic [STW-1:0] r_step;

    // output register
    logic r_out_valid;

    logic [LW-1:0]   win_len;
    logic [LW-1:0]   pos_inc;
    logic            win_end;
    logic            div_last;
    logic            out_free;
    logic            sample_ok;
    logic            drop_hit;
    logic [CW:0]     div_trial;
    logic            div_ge;
    logic [CW-1:0]   n_div_rem;
    logic [UW-1:0]   over_bound;
    logic            none_valid;
    logic [AW-1:0]   avg_sat;
    logic [1:0]      fault;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_limit     <= wswm_pkg::NOISE_LIMIT_RST;
            r_drop_threshold  <= wswm_pkg::DROP_THRESHOLD_RST;
            r_overspeed_limit <= wswm_pkg::OVERSPEED_LIMIT_RST;
            r_window_length   <= wswm_pkg::WINDOW_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (wswm_pkg::t_cfg_idx'(i_cfg_idx))
                wswm_pkg::CFG_NOISE_LIMIT:     r_noise_limit     <= i_cfg_data;
                wswm_pkg::CFG_DROP_THRESHOLD:  r_drop_threshold  <= i_cfg_data;
                wswm_pkg::CFG_OVERSPEED_LIMIT: r_overspeed_limit <= i_cfg_data;
                wswm_pkg::CFG_WINDOW_LENGTH:   r_window_length   <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // window end test, a zero length counts as one
    assign win_len = (r_window_length == '0) ? LW'(1) : r_window_length;
    assign pos_inc = r_pos + LW'(1);
    assign win_end = (pos_inc >= win_len);

    // status back to the controller
    assign o_status = {win_end, div_last, out_free};

    // per-sample update
    always_comb begin
        sample_ok = (i_speed_sample <= r_noise_limit);
        drop_hit  = sample_ok && (r_pos != '0) && (i_speed_sample == '0)
                    && (r_prev > r_drop_threshold) && (r_prev < r_noise_limit);
        n_sum  = r_sum;
        n_cnt  = r_cnt;
        n_max  = r_max;
        n_min  = r_min;
        n_drop = r_drop || drop_hit;
        if (sample_ok) begin
            n_sum = r_sum + UW'(i_speed_sample);
            n_cnt = r_cnt + CW'(1);
            if (i_speed_sample > r_max) begin
                n_max = i_speed_sample;
            end
            if (i_speed_sample < r_min) begin
                n_min = i_speed_sample;
            end
        end
    end

    // accumulators, cleared when a window closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_max  <= '0;
            r_min  <= wswm_pkg::MIN_RST;
            r_prev <= '0;
            r_pos  <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.acc) begin
            if (win_end) begin
                r_sum  <= '0;
                r_cnt  <= '0;
                r_max  <= '0;
                r_min  <= wswm_pkg::MIN_RST;
                r_prev <= '0;
                r_pos  <= '0;
                r_drop <= 1'b0;
            end else begin
                r_sum  <= n_sum;
                r_cnt  <= n_cnt;
                r_max  <= n_max;
                r_min  <= n_min;
                r_prev <= i_speed_sample;
                r_pos  <= pos_inc;
                r_drop <= n_drop;
            end
        end
    end

    // restoring divider step, one quotient bit a cycle
    assign div_trial = {r_div_rem, r_div_q[DW-1]};
    assign div_ge    = (div_trial >= {1'b0, r_snap_cnt});
    assign n_div_rem = div_ge ? CW'(div_trial - {1'b0, r_snap_cnt}) : div_trial[CW-1:0];
    assign div_last  = (r_step == STW'(DW - 1));

    // snapshot and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_snap_sum  <= n_sum;
            r_snap_cnt  <= n_cnt;
            r_snap_max  <= n_max;
            r_snap_min  <= n_min;
            r_snap_drop <= n_drop;
            r_div_q     <= DW'(n_sum) << AVG_FRAC_BITS;
            r_div_rem   <= '0;
            r_step      <= '0;
        end else if (i_cmd.div_step) begin
            r_div_q   <= {r_div_q[DW-2:0], div_ge};
            r_div_rem <= n_div_rem;
            r_step    <= r_step + STW'(1);
        end
    end

    // report fields from the finished division
    always_comb begin
        none_valid = (r_snap_cnt == '0);
        over_bound = UW'(r_overspeed_limit) * UW'(r_snap_cnt);
        avg_sat    = (r_div_q > AVG_SAT) ? {AW{1'b1}} : r_div_q[AW-1:0];
        if (none_valid) begin
            fault = wswm_pkg::FAULT_NONE;
        end else if (r_snap_drop) begin
            fault = wswm_pkg::FAULT_DROP;
        end else if (r_snap_sum > over_bound) begin
            fault = wswm_pkg::FAULT_OVERSPEED;
        end else begin
            fault = wswm_pkg::FAULT_NONE;
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_average_q8    <= none_valid ? '0 : avg_sat;
            o_speed_max     <= none_valid ? '0 : r_snap_max;
            o_speed_min     <= none_valid ? '0 : r_snap_min;
            o_valid_samples <= r_snap_cnt;
            o_fault_code    <= fault;
            o_all_discarded <= none_valid;
        end
    end

    assign o_valid = r_out_valid;

    // a report is loaded only when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("report loaded over a held report");

    // a new window never starts while the divider runs
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !i_cmd.div_step && !i_cmd.out_load)
        else $error("window closed while divider busy");

    // divider restarts from the first bit
    a_step_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> (r_step == '0))
        else $error("divider step count not cleared");

    // running extremes stay ordered once a sample counted
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_min <= r_max))
        else $error("running minimum above maximum");

    // an empty window reports zeros and no fault
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_all_discarded) |-> (o_average_q8 == '0) && (o_speed_max == '0)
            && (o_speed_min == '0) && (o_fault_code == wswm_pkg::FAULT_NONE))
        else $error("empty window report not cleared");

endmodule

`default_nettype wire

/* hw/rtl/wheel_speed_window_monitor_core.sv */
// top level of the wheel speed window monitor
// Usage:
// Speed samples enter on i_speed_sample with i_valid / o_stall; one report per
// window leaves on o_valid / i_stall with the average, extremes, count and fault.
// Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data (0 noise limit,
// 1 drop threshold, 2 overspeed limit, 3 window length) while no report is pending.
// Samples are taken one per cycle while o_stall is low. The sample that closes a
// window starts a bit-serial divider over a 24 + AVG_FRAC_BITS bit dividend (32 bits
// at the default); the report then leaves through the output register onto o_valid.
// Samples of the next window keep flowing during the division; only the next
// window's closing sample is stalled until the divider and its report slot are free.
// A held report (i_stall high) keeps the divider result waiting, which in turn
// stalls the next closing sample.
// Synchronous active-low reset restores the register defaults (250, 30, 120,
// 10), clears the window and drops o_valid; the block takes samples in the
// cycle after reset is released.
`default_nettype none

module wheel_speed_window_monitor_core #(
    parameter int AVG_FRAC_BITS = wswm_pkg::AVG_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [wswm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wswm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [wswm_pkg::SPEED_W-1:0]    i_speed_sample,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [wswm_pkg::AVG_W-1:0]           o_average_q8,
    output logic [wswm_pkg::SPEED_W-1:0]         o_speed_max,
    output logic [wswm_pkg::SPEED_W-1:0]         o_speed_min,
    output logic [wswm_pkg::CNT_W-1:0]           o_valid_samples,
    output logic [1:0]                           o_fault_code,
    output logic                                 o_all_discarded
);

    wswm_pkg::t_cmd    cmd;
    wswm_pkg::t_status status;

    // sequencing
    wswm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic and storage
    wswm_dp #(
        .AVG_FRAC_BITS (AVG_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_speed_sample  (i_speed_sample),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_average_q8    (o_average_q8),
        .o_speed_max     (o_speed_max),
        .o_speed_min     (o_speed_min),
        .o_valid_samples (o_valid_samples),
        .o_fault_code    (o_fault_code),
        .o_all_discarded (o_all_discarded)
    );

endmodule

`default_nettype wire

/* tb/wheel_speed_window_monitor_core_tb.sv */
// testbench of the wheel speed window monitor core: directed and random windows
`timescale 1ns / 100ps

module wheel_speed_window_monitor_core_tb;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int AVG_FRAC       = wswm_pkg::AVG_FRAC_BITS_DEF;
    localparam longint unsigned AVG_SAT = 64'hFF_FFFF;

    localparam int SPEED_W = wswm_pkg::SPEED_W;
    localparam int AVG_W   = wswm_pkg::AVG_W;
    localparam int CNT_W   = wswm_pkg::CNT_W;
    localparam int LEN_W   = wswm_pkg::LEN_W;
    localparam int SUM_W   = wswm_pkg::SUM_W;
    localparam int CFG_W   = wswm_pkg::CFG_W;

    // one window report as the block presents it
    typedef struct packed {
        logic [AVG_W-1:0]   average_q8;
        logic [SPEED_W-1:0] speed_max;
        logic [SPEED_W-1:0] speed_min;
        logic [CNT_W-1:0]   valid_samples;
        logic [1:0]         fault_code;
        logic               all_discarded;
    } t_speed_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    wswm_pkg::t_cfg_idx   i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [SPEED_W-1:0]   i_speed_sample;
    logic                 o_valid;
    logic                 i_stall;
    logic [AVG_W-1:0]     o_average_q8;
    logic [SPEED_W-1:0]   o_speed_max;
    logic [SPEED_W-1:0]   o_speed_min;
    logic [CNT_W-1:0]     o_valid_samples;
    logic [1:0]           o_fault_code;
    logic                 o_all_discarded;

    // limits as the block holds them
    logic [SPEED_W-1:0] noise_lim;
    logic [SPEED_W-1:0] drop_thr;
    logic [SPEED_W-1:0] ovs_lim;
    logic [LEN_W-1:0]   win_len_reg;

    // window being collected
    logic [SUM_W-1:0]   win_sum;
    logic [CNT_W-1:0]   win_count;
    logic [SPEED_W-1:0] win_max;
    logic [SPEED_W-1:0] win_min;
    logic [SPEED_W-1:0] last_raw;
    logic [LEN_W-1:0]   win_pos;
    logic               drop_flag;

    t_speed_report pending_reports[$];
    int  bad_reports = 0;
    int  idle_cycles = 0;
    bit  src_idle_en = 1'b1;
    bit  snk_idle_en = 1'b1;

    wheel_speed_window_monitor_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_speed_sample  (i_speed_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_average_q8    (o_average_q8),
        .o_speed_max     (o_speed_max),
        .o_speed_min     (o_speed_min),
        .o_valid_samples (o_valid_samples),
        .o_fault_code    (o_fault_code),
        .o_all_discarded (o_all_discarded)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void clear_window_state();
        win_sum   = '0;
        win_count = '0;
        win_max   = '0;
        win_min   = wswm_pkg::MIN_RST;
        last_raw  = '0;
        win_pos   = '0;
        drop_flag = 1'b0;
    endfunction

    // fold one sample into the window, queue a report when it closes
    function automatic void take_speed_sample(logic [SPEED_W-1:0] s);
        logic [LEN_W-1:0] span;
        t_speed_report    rep;
        longint unsigned  quot;
        span = (win_len_reg == '0) ? LEN_W'(1) : win_len_reg;
        if (s <= noise_lim) begin
            win_sum   = win_sum + SUM_W'(s);
            win_count = win_count + 1'b1;
            if (win_pos != '0 && s == '0 && last_raw > drop_thr && last_raw < noise_lim)
                drop_flag = 1'b1;
            if (s > win_max) win_max = s;
            if (s < win_min) win_min = s;
        end
        last_raw = s;
        win_pos  = win_pos + 1'b1;
        if (win_pos >= span) begin
            rep = '0;
            if (win_count != '0) begin
                quot = (64'(win_sum) << AVG_FRAC) / 64'(win_count);
                if (quot > AVG_SAT) quot = AVG_SAT;
                rep.average_q8 = AVG_W'(quot);
                rep.speed_max  = win_max;
                rep.speed_min  = win_min;
                if (drop_flag)
                    rep.fault_code = wswm_pkg::FAULT_DROP;
                else if (64'(win_sum) > 64'(ovs_lim) * 64'(win_count))
                    rep.fault_code = wswm_pkg::FAULT_OVERSPEED;
                else
                    rep.fault_code = wswm_pkg::FAULT_NONE;
            end else begin
                rep.all_discarded = 1'b1;
                rep.fault_code    = wswm_pkg::FAULT_NONE;
            end
            rep.valid_samples = win_count;
            pending_reports.push_back(rep);
            clear_window_state();
        end
    endfunction

    // samples weighted toward the limits, zeros and drop patterns
    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3, 4: return SPEED_W'($urandom_range(0, noise_lim));
            5:       return noise_lim + SPEED_W'($urandom_range(0, 2));
            6:       return drop_thr + SPEED_W'($urandom_range(0, 2));
            7:       return ovs_lim + SPEED_W'($urandom_range(0, 2));
            8:       return SPEED_W'($urandom_range(drop_thr, noise_lim));
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    // send one sample item, called and left at a falling edge
    task automatic send_sample(logic [SPEED_W-1:0] s);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_speed_sample <= s;
        do @(posedge i_clk); while (o_stall);
        take_speed_sample(s);
        @(negedge i_clk);
    endtask

    // hold the sender until every report is in, then let the block settle
    task automatic wait_for_reports(int settle);
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(wswm_pkg::t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            wswm_pkg::CFG_NOISE_LIMIT:     noise_lim   = val;
            wswm_pkg::CFG_DROP_THRESHOLD:  drop_thr    = val;
            wswm_pkg::CFG_OVERSPEED_LIMIT: ovs_lim     = val;
            wswm_pkg::CFG_WINDOW_LENGTH:   win_len_reg = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_limits(logic [CFG_W-1:0] noise, logic [CFG_W-1:0] thr,
                                  logic [CFG_W-1:0] ovs, logic [CFG_W-1:0] len_word);
        wait_for_reports(SETTLE_CYCLES);
        write_reg(wswm_pkg::CFG_NOISE_LIMIT, noise);
        write_reg(wswm_pkg::CFG_DROP_THRESHOLD, thr);
        write_reg(wswm_pkg::CFG_OVERSPEED_LIMIT, ovs);
        write_reg(wswm_pkg::CFG_WINDOW_LENGTH, len_word);
        i_cfg_we <= 1'b0;
    endtask

    // reset limits: rejected sample, sample at the noise limit, zero after
    // the noise limit and after the drop threshold, average just below overspeed
    task automatic test_default_window();
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd250);
        send_sample(16'd0);
        send_sample(16'd30);
        send_sample(16'd0);
        send_sample(16'd249);
        send_sample(16'd200);
        send_sample(16'd180);
        send_sample(16'd170);
    endtask

    // zero after a sample just above the threshold raises the drop fault
    task automatic test_drop_window();
        program_limits(16'd250, 16'd30, 16'd120, 16'd3);
        send_sample(16'd31);
        send_sample(16'd0);
        send_sample(16'd0);
    endtask

    // one-sample windows, all-rejected window, length zero taken as one
    task automatic test_single_sample_windows();
        program_limits(16'd250, 16'd30, 16'd120, 16'd1);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        program_limits(16'd250, 16'd30, 16'd120, 16'hA500);
        send_sample(16'd7);
    endtask

    // widest noise limit, zero threshold and zero overspeed limit
    task automatic test_extreme_limits();
        program_limits(16'hFFFF, 16'd0, 16'd0, 16'd3);
        send_sample(16'hFFFF);
        send_sample(16'd0);
        send_sample(16'd1);
    endtask

    // length lowered below the samples already taken closes on the next one
    task automatic test_length_change_mid_window();
        program_limits(16'd250, 16'd30, 16'd120, 16'd10);
        send_sample(16'd40);
        send_sample(16'd90);
        send_sample(16'd0);
        send_sample(16'd251);
        send_sample(16'd120);
        program_limits(16'd250, 16'd30, 16'd120, 16'd3);
        send_sample(16'd60);
    endtask

    task automatic program_random_limits(int phase);
        logic [CFG_W-1:0] noise, thr, ovs;
        logic [LEN_W-1:0] span;
        case ($urandom_range(0, 5))
            0:       noise = '0;
            1:       noise = 16'hFFFF;
            2, 3:    noise = CFG_W'($urandom_range(100, 400));
            default: noise = CFG_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       thr = '0;
            1:       thr = 16'hFFFF;
            default: thr = CFG_W'($urandom_range(0, noise));
        endcase
        case ($urandom_range(0, 4))
            0:       ovs = '0;
            1:       ovs = 16'hFFFF;
            default: ovs = CFG_W'($urandom_range(0, noise));
        endcase
        if (phase == 1)
            span = 8'd255;
        else if (phase == 2)
            span = 8'd0;
        else begin
            case ($urandom_range(0, 5))
                0:       span = 8'd1;
                1:       span = LEN_W'($urandom_range(13, 40));
                default: span = LEN_W'($urandom_range(2, 12));
            endcase
        end
        program_limits(noise, thr, ovs, {8'($urandom), span});
    endtask

    // random limits per phase; phases end mid-window on purpose
    task automatic test_random_windows();
        int n;
        for (int phase = 0; phase < 13; phase++) begin
            src_idle_en = (phase % 4 != 3);
            snk_idle_en = (phase % 3 != 2);
            program_random_limits(phase);
            n = (win_len_reg > 8'd40) ? 2 * win_len_reg + $urandom_range(0, 20)
                                      : $urandom_range(60, 140);
            for (int k = 0; k < n; k++) begin
                send_sample(pick_speed());
                if ($urandom_range(0, 99) == 0 || k == n / 2)
                    wait_for_reports(0);
            end
        end
    endtask

    // back-to-back samples and no stalls at the tail of the run
    task automatic test_steady_stream();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        program_limits(16'd250, 16'd30, 16'd120, CFG_W'($urandom_range(2, 8)));
        for (int k = 0; k < 150; k++)
            send_sample(pick_speed());
    endtask

    // receiver stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // compare each report with the oldest one predicted
    always @(posedge i_clk) begin
        t_speed_report got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_average_q8, o_speed_max, o_speed_min, o_valid_samples,
                   o_fault_code, o_all_discarded};
            if (pending_reports.size() == 0) begin
                if (bad_reports < 10)
                    $display("unexpected report at %0t ns: avg %0d cnt %0d",
                             $time, got.average_q8, got.valid_samples);
                bad_reports++;
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    if (bad_reports < 10)
                        $display({"report mismatch at %0t ns: avg %0d/%0d max %0d/%0d",
                                  " min %0d/%0d cnt %0d/%0d fault %0d/%0d none %0d/%0d",
                                  " (expected/actual)"},
                                 $time, want.average_q8, got.average_q8,
                                 want.speed_max, got.speed_max,
                                 want.speed_min, got.speed_min,
                                 want.valid_samples, got.valid_samples,
                                 want.fault_code, got.fault_code,
                                 want.all_discarded, got.all_discarded);
                    bad_reports++;
                end
            end
        end
    end

    // no item on either side for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = wswm_pkg::CFG_NOISE_LIMIT;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_speed_sample = '0;
        noise_lim      = wswm_pkg::NOISE_LIMIT_RST;
        drop_thr       = wswm_pkg::DROP_THRESHOLD_RST;
        ovs_lim        = wswm_pkg::OVERSPEED_LIMIT_RST;
        win_len_reg    = wswm_pkg::WINDOW_LENGTH_RST;
        clear_window_state();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_window();
        test_drop_window();
        test_single_sample_windows();
        test_extreme_limits();
        test_length_change_mid_window();
        test_random_windows();
        test_steady_stream();

        wait_for_reports(SETTLE_CYCLES);
        if (bad_reports == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/wswm_pkg.sv
hw/rtl/wswm_ctrl.sv
hw/rtl/wswm_dp.sv
hw/rtl/wheel_speed_window_monitor_core.sv
tb/wheel_speed_window_monitor_core_tb.sv
